>>> src/fqd_pkg.sv
package fqd_pkg;

    // queue geometry
    localparam int DEPTH       = 16;
    localparam int HANDLE_BITS = 32;

    // fixed field widths of the request and response
    localparam int VAL_W = 32;
    localparam int LEN_W = 5;
    localparam int OP_W  = 2;

    // derived widths
    localparam int HW     = (HANDLE_BITS < VAL_W) ? HANDLE_BITS : VAL_W;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // operation codes
    localparam logic [OP_W-1:0] OP_ENQ = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQ = 2'd1;
    localparam logic [OP_W-1:0] OP_DEL = 2'd2;

    // status codes
    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]  req_type;
        logic [VAL_W-1:0] item_value;
    } t_in;

    typedef struct packed {
        logic             status;
        logic [VAL_W-1:0] out_value;
        logic [LEN_W-1:0] fill_level;
    } t_out;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_SHIFT  = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

endpackage

>>> src/fifo_queue_with_delete_top.sv
// enqueue, null, full, empty or unknown requests pass from the sequencer state register to
// the output register; dequeue and delete walk the entry store one entry a cycle through
// its single registered read port, then move later entries up
// one request at a time: the input stalls until the response leaves the sequencer
// reset: synchronous active-low, empties the queue; stored handles are not cleared
module fifo_queue_with_delete_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  fqd_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output fqd_pkg::t_out o_out_data
);

    logic          res_valid;
    logic          res_take;
    fqd_pkg::t_out res;

    logic          r_out_valid;
    fqd_pkg::t_out r_out_data;

    fqd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_in_valid),
        .i_req       (i_in_data),
        .o_req_stall (o_in_stall),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take)
    );

    // output register takes the sequencer's response when empty or when its held response is taken
    assign res_take = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take && res_valid) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> src/fqd_core.sv
module fqd_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_req_valid,
    input  fqd_pkg::t_in i_req,
    output logic         o_req_stall,
    output logic         o_res_valid,
    output fqd_pkg::t_out o_res,
    input  logic         i_res_take
);

    // entry storage, index 0 oldest
    logic [fqd_pkg::HW-1:0] mem [fqd_pkg::DEPTH];

    fqd_pkg::t_state r_state, n_state;
    logic [fqd_pkg::CNT_W-1:0]  r_count, n_count;
    logic [fqd_pkg::CNT_W-1:0]  r_ptr, n_ptr;
    logic [fqd_pkg::HW-1:0]     r_handle, n_handle;
    logic                       r_is_deq, n_is_deq;
    logic                       r_status, n_status;
    logic [fqd_pkg::HW-1:0]     r_val, n_val;
    logic                       r_rd_vld;
    logic [fqd_pkg::ADDR_W-1:0] r_rd_idx;
    logic [fqd_pkg::HW-1:0]     r_rd_data;

    logic                       issue;
    logic                       wr_en;
    logic [fqd_pkg::ADDR_W-1:0] wr_addr;
    logic [fqd_pkg::HW-1:0]     wr_data;
    logic [fqd_pkg::HW-1:0]     handle_in;
    logic                       rd_last;
    logic                       rd_match;

    assign handle_in = i_req.item_value[fqd_pkg::HW-1:0];
    assign rd_last   = (fqd_pkg::CNT_W'(r_rd_idx) == (r_count - fqd_pkg::CNT_W'(1)));
    assign rd_match  = r_is_deq || (r_rd_data == r_handle);

    // sequencer: decode; dequeue and delete scan one entry a cycle, then shift later entries up on a hit
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ptr    = r_ptr;
        n_handle = r_handle;
        n_is_deq = r_is_deq;
        n_status = r_status;
        n_val    = r_val;
        issue    = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = '0;
        wr_data  = '0;
        case (r_state)
            fqd_pkg::S_IDLE: begin
                if (i_req_valid) begin
                    n_handle = handle_in;
                    n_status = fqd_pkg::ST_ERR;
                    n_val    = '0;
                    n_ptr    = '0;
                    n_is_deq = 1'b0;
                    n_state  = fqd_pkg::S_FINISH;
                    case (i_req.req_type)
                        fqd_pkg::OP_ENQ: begin
                            if (handle_in != '0 &&
                                r_count < fqd_pkg::CNT_W'(fqd_pkg::DEPTH)) begin
                                wr_en    = 1'b1;
                                wr_addr  = r_count[fqd_pkg::ADDR_W-1:0];
                                wr_data  = handle_in;
                                n_count  = r_count + fqd_pkg::CNT_W'(1);
                                n_status = fqd_pkg::ST_OK;
                            end
                        end
                        fqd_pkg::OP_DEQ: begin
                            if (r_count != '0) begin
                                n_is_deq = 1'b1;
                                n_state  = fqd_pkg::S_SCAN;
                            end
                        end
                        fqd_pkg::OP_DEL: begin
                            if (handle_in != '0 && r_count != '0) begin
                                n_state = fqd_pkg::S_SCAN;
                            end
                        end
                        default: begin
                            n_state = fqd_pkg::S_FINISH;
                        end
                    endcase
                end
            end
            fqd_pkg::S_SCAN: begin
                issue = (r_ptr < r_count);
                if (issue) begin
                    n_ptr = r_ptr + fqd_pkg::CNT_W'(1);
                end
                if (r_rd_vld) begin
                    if (rd_match) begin
                        n_status = fqd_pkg::ST_OK;
                        if (r_is_deq) begin
                            n_val = r_rd_data;
                        end
                        n_state = fqd_pkg::S_SHIFT;
                    end else if (rd_last) begin
                        n_state = fqd_pkg::S_FINISH;
                    end
                end
            end
            fqd_pkg::S_SHIFT: begin
                issue = (r_ptr < r_count);
                if (issue) begin
                    n_ptr = r_ptr + fqd_pkg::CNT_W'(1);
                end
                if (r_rd_vld) begin
                    wr_en   = 1'b1;
                    wr_addr = r_rd_idx - fqd_pkg::ADDR_W'(1);
                    wr_data = r_rd_data;
                end else if (!issue) begin
                    n_count = r_count - fqd_pkg::CNT_W'(1);
                    n_state = fqd_pkg::S_FINISH;
                end
            end
            fqd_pkg::S_FINISH: begin
                if (i_res_take) begin
                    n_state = fqd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fqd_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= fqd_pkg::S_IDLE;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_vld <= issue;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_handle <= n_handle;
        r_is_deq <= n_is_deq;
        r_status <= n_status;
        r_val    <= n_val;
        r_rd_idx <= r_ptr[fqd_pkg::ADDR_W-1:0];
    end

    // storage with one write port and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[r_ptr[fqd_pkg::ADDR_W-1:0]];
    end

    assign o_req_stall = (r_state != fqd_pkg::S_IDLE);
    assign o_res_valid = (r_state == fqd_pkg::S_FINISH);
    assign o_res.status     = r_status;
    assign o_res.out_value  = fqd_pkg::VAL_W'(r_val);
    assign o_res.fill_level = fqd_pkg::LEN_W'(r_count);

    // count stays within the queue depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= fqd_pkg::CNT_W'(fqd_pkg::DEPTH))
        else $error("entry count beyond depth");

    // no storage write while scanning
    a_no_write_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fqd_pkg::S_SCAN) |-> !wr_en)
        else $error("write during scan");

    // reads in flight always target a held entry
    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (fqd_pkg::CNT_W'(r_rd_idx) < r_count))
        else $error("read beyond held entries");

    // a finished shift removes exactly one entry
    a_shift_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fqd_pkg::S_SHIFT && n_state == fqd_pkg::S_FINISH)
        |=> (r_count == $past(r_count) - fqd_pkg::CNT_W'(1)))
        else $error("shift did not remove one entry");

endmodule

>>> dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS       = 1700;
    localparam int QUIET_ITEMS = 200;
    localparam int DRAIN_WAIT  = 30;
    localparam int STUCK_LIMIT = 2000;
    localparam logic [fqd_pkg::OP_W-1:0] OP_BAD = 2'd3;
    localparam logic [fqd_pkg::VAL_W-1:0] HANDLE_MASK =
        (fqd_pkg::HW >= fqd_pkg::VAL_W) ? '1 :
        ((fqd_pkg::VAL_W'(1) << fqd_pkg::HW) - fqd_pkg::VAL_W'(1));

    // shadow queue: predicts each response and checks what the block returns
    class fifo_shadow;
        logic [fqd_pkg::VAL_W-1:0] held[$];
        fqd_pkg::t_out             due[$];
        int                        fails;

        function new();
            fails = 0;
        endfunction

        function int pending();
            return due.size();
        endfunction

        task report_mismatch(input string msg);
            fails++;
            $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        // apply one accepted request to the shadow state
        function void note_request(input fqd_pkg::t_in req);
            fqd_pkg::t_out             rsp;
            logic [fqd_pkg::VAL_W-1:0] h;
            int                        hit;
            h = req.item_value & HANDLE_MASK;
            rsp.status    = fqd_pkg::ST_ERR;
            rsp.out_value = '0;
            hit = -1;
            case (req.req_type)
                fqd_pkg::OP_ENQ: begin
                    if (h != '0 && held.size() < fqd_pkg::DEPTH) begin
                        held.push_back(h);
                        rsp.status = fqd_pkg::ST_OK;
                    end
                end
                fqd_pkg::OP_DEQ: begin
                    if (held.size() != 0) begin
                        rsp.out_value = held.pop_front();
                        rsp.status    = fqd_pkg::ST_OK;
                    end
                end
                fqd_pkg::OP_DEL: begin
                    if (h != '0) begin
                        for (int k = 0; k < held.size(); k++) begin
                            if (held[k] == h) begin
                                hit = k;
                                break;
                            end
                        end
                        if (hit >= 0) begin
                            held.delete(hit);
                            rsp.status = fqd_pkg::ST_OK;
                        end
                    end
                end
                default: ;
            endcase
            rsp.fill_level = fqd_pkg::LEN_W'(held.size());
            due.push_back(rsp);
        endfunction

        // compare one returned response with the oldest prediction
        task check_response(input fqd_pkg::t_out got);
            fqd_pkg::t_out want;
            if (due.size() == 0) begin
                report_mismatch("response with no request outstanding");
                return;
            end
            want = due.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status got %0b want %0b",
                                          got.status, want.status));
            if (got.out_value !== want.out_value)
                report_mismatch($sformatf("out_value got %h want %h",
                                          got.out_value, want.out_value));
            if (got.fill_level !== want.fill_level)
                report_mismatch($sformatf("fill_level got %0d want %0d",
                                          got.fill_level, want.fill_level));
        endtask
    endclass

    logic          i_clk;
    logic          rst_n     = 1'b0;
    logic          in_valid  = 1'b0;
    fqd_pkg::t_in  in_data   = '0;
    logic          out_stall = 1'b0;
    logic          o_in_stall;
    logic          o_out_valid;
    fqd_pkg::t_out o_out_data;

    int idle_pct     = 0;
    int stall_left   = 0;
    int stuck_cycles = 0;

    fifo_shadow shadow = new();

    fifo_queue_with_delete_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // response side stalls in short bursts
    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 3);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // collect responses
    always @(posedge i_clk) begin
        if (rst_n && o_out_valid && !out_stall)
            shadow.check_response(o_out_data);
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (!rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles == STUCK_LIMIT) begin
                $display("fifo_queue_with_delete_top verification failed");
                $finish;
            end
        end
    end

    function automatic fqd_pkg::t_in make_req(input logic [fqd_pkg::OP_W-1:0] op,
                                              input logic [fqd_pkg::VAL_W-1:0] v);
        fqd_pkg::t_in r;
        r.req_type   = op;
        r.item_value = v;
        return r;
    endfunction

    // drive one request, with an optional gap ahead of it
    task automatic send_request(input fqd_pkg::t_in req);
        int gap;
        gap = 0;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            gap = $urandom_range(1, 4);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge i_clk); while (o_in_stall);
        shadow.note_request(req);
    endtask

    // hold off until every predicted response has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (shadow.pending() != 0);
    endtask

    // many small handles so duplicates and hits happen, half wide and some null
    function automatic logic [fqd_pkg::VAL_W-1:0] pick_handle();
        int s;
        s = $urandom_range(0, 19);
        if (s == 0)
            return '0;
        else if (s < 10)
            return fqd_pkg::VAL_W'($urandom_range(1, 8));
        else
            return fqd_pkg::VAL_W'($urandom);
    endfunction

    // random request; bias 0 fills, 1 balanced, 2 drains
    function automatic fqd_pkg::t_in random_req(input int bias);
        int                        r;
        int                        enq_w;
        logic [fqd_pkg::VAL_W-1:0] v;
        r     = $urandom_range(0, 99);
        enq_w = (bias == 0) ? 60 : (bias == 1) ? 40 : 20;
        if (r < enq_w)
            return make_req(fqd_pkg::OP_ENQ, pick_handle());
        if (r < enq_w + (100 - enq_w) / 2)
            return make_req(fqd_pkg::OP_DEQ, fqd_pkg::VAL_W'($urandom));
        if (r < 97) begin
            if (shadow.held.size() != 0 && $urandom_range(0, 3) != 0)
                v = shadow.held[$urandom_range(0, shadow.held.size() - 1)];
            else
                v = pick_handle();
            return make_req(fqd_pkg::OP_DEL, v);
        end
        return make_req(OP_BAD, fqd_pkg::VAL_W'($urandom));
    endfunction

    initial begin
        int bias;
        bias = 1;

        repeat (2) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty queue errors, null handles, unknown operation
        idle_pct = 15;
        send_request(make_req(fqd_pkg::OP_DEQ, 32'h0000_0000));
        send_request(make_req(fqd_pkg::OP_DEL, 32'h0000_0005));
        send_request(make_req(OP_BAD, 32'hFFFF_FFFF));
        send_request(make_req(fqd_pkg::OP_ENQ, 32'h0000_0000));
        send_request(make_req(fqd_pkg::OP_DEL, 32'h0000_0000));

        // fill to the top, with a duplicate and the extreme handles
        send_request(make_req(fqd_pkg::OP_ENQ, 32'hFFFF_FFFF));
        send_request(make_req(fqd_pkg::OP_ENQ, 32'h0000_0001));
        send_request(make_req(fqd_pkg::OP_ENQ, 32'h0000_0007));
        send_request(make_req(fqd_pkg::OP_ENQ, 32'h8000_0000));
        send_request(make_req(fqd_pkg::OP_ENQ, 32'h0000_0007));
        for (int i = 0; i < fqd_pkg::DEPTH - 5; i++)
            send_request(make_req(fqd_pkg::OP_ENQ, 32'h0000_0100 + i));
        send_request(make_req(fqd_pkg::OP_ENQ, 32'h0000_0042));

        // delete the first of two equal handles, a miss, then pop the head
        send_request(make_req(fqd_pkg::OP_DEL, 32'h0000_0007));
        send_request(make_req(fqd_pkg::OP_DEL, 32'h0001_2345));
        send_request(make_req(fqd_pkg::OP_DEQ, 32'h0000_0000));
        wait_drained();

        // random traffic in segments of varying idling and fill bias
        for (int n = 0; n < ITEMS - 25; n++) begin
            if (n % 100 == 0) begin
                bias = $urandom_range(0, 2);
                case ($urandom_range(0, 2))
                    0: idle_pct = 0;
                    1: idle_pct = 15;
                    default: idle_pct = 40;
                endcase
            end
            if (n >= ITEMS - 25 - QUIET_ITEMS)
                idle_pct = 0;
            if (n % 400 == 399)
                wait_drained();
            send_request(random_req(bias));
        end

        // drain and let the last response settle
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (shadow.fails == 0 && shadow.pending() == 0)
            $display("fifo_queue_with_delete_top verification clean");
        else
            $display("fifo_queue_with_delete_top verification failed");
        $finish;
    end
endmodule

>>> sim.f
src/fqd_pkg.sv
src/fqd_core.sv
src/fifo_queue_with_delete_top.sv
dv/tb_top.sv
